FILE: hdl/cbf_pkg.sv
package cbf_pkg;

    // fixed formats
    localparam int COORD_WIDTH = 32;
    localparam int MAX_SLICES  = 63;
    localparam int SLICE_W     = 6;
    localparam int PT_W        = COORD_WIDTH + 1;       // exact control point
    localparam int T_W         = 17;                    // t, u in Q1.16
    localparam int NUM_W       = SLICE_W + 16;          // divider numerator
    localparam int MUL_A_W     = PT_W + 1;              // signed multiplier operand
    localparam int MUL_P_W     = MUL_A_W + T_W + 1;     // signed product
    localparam int W_W         = 49;                    // Bernstein weight, Q.48
    localparam int SQ_W        = 33;                    // u^2, t^2
    localparam int CHUNKS      = 3;                     // weight split into T_W slices
    localparam int ACC_W       = MUL_P_W + 2 * T_W;
    localparam int RS_W        = ACC_W - 48;
    localparam int WGT_STEPS   = 6;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] start_dir_x;
        logic signed [COORD_WIDTH-1:0] start_dir_y;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
        logic signed [COORD_WIDTH-1:0] end_dir_x;
        logic signed [COORD_WIDTH-1:0] end_dir_y;
        logic [SLICE_W-1:0]            slice_count;
    } in_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic                          last_point;
    } out_t;

    // classified curve job handed from front to back
    typedef struct packed {
        logic [3:0][PT_W-1:0] px;
        logic [3:0][PT_W-1:0] py;
        logic [SLICE_W-1:0]   n;
        logic                 ctrl;   // emit control points only
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PREP,
        BK_DIV,
        BK_WGT,
        BK_MAC,
        BK_RND,
        BK_OUT
    } bk_state_t;

    // weight microcode steps
    localparam logic [4:0] WS_U2 = 5'd0;
    localparam logic [4:0] WS_T2 = 5'd1;
    localparam logic [4:0] WS_W0 = 5'd2;
    localparam logic [4:0] WS_W3 = 5'd3;
    localparam logic [4:0] WS_W1 = 5'd4;
    localparam logic [4:0] WS_W2 = 5'd5;

endpackage

FILE: hdl/cubic_bezier_flatten.sv
// Cubic Bezier flattener. Each request carries start and end points with
// their direction vectors (signed Q15.16) and a slice count; the block emits
// slice_count + 1 curve points (t = slice / slice_count, rounded to Q1.16),
// or the four control points when the count is zero, last_point marking the
// final one. Requests enter a small queue while it has room, so a new curve is
// taken while the previous one is still being worked. Points come out of one
// shared 34x17 multiplier: each curve point takes a setup step, the bit-serial
// t divider, the Bernstein weights, a multiply-accumulate pass plus rounding
// for x and then for y, and a hand-off that waits for the output to be free;
// a zero-count request skips the divider and the weights.
module cubic_bezier_flatten #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  cbf_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output cbf_pkg::out_t m_data
);
    import cbf_pkg::*;

    job_t front_job, queue_job;
    logic q_pop_valid, q_pop_ready, back_busy;

    cbf_front u_front (
        .req (s_data),
        .job (front_job)
    );

    cbf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_data  (front_job),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (queue_job)
    );

    cbf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (q_pop_valid),
        .job_ready (q_pop_ready),
        .job_in    (queue_job),
        .busy      (back_busy),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // output register is empty right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a queued request is visible to the back end on the next cycle
    a_push_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> q_pop_valid || back_busy)
        else $error("accepted request lost");

    // taking a job from the queue starts the back end
    a_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop_valid && q_pop_ready |=> back_busy)
        else $error("job popped while back end stays idle");

    // a new result appears only while a curve is in work
    a_result_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(back_busy))
        else $error("result without active curve");

endmodule

FILE: hdl/cbf_front.sv
module cbf_front (
    input  cbf_pkg::in_t  req,
    output cbf_pkg::job_t job
);
    import cbf_pkg::*;

    logic signed [PT_W-1:0] sx, sy, ex, ey;

    // widen to exact point width
    assign sx = {req.start_x[COORD_WIDTH-1], req.start_x};
    assign sy = {req.start_y[COORD_WIDTH-1], req.start_y};
    assign ex = {req.end_x[COORD_WIDTH-1], req.end_x};
    assign ey = {req.end_y[COORD_WIDTH-1], req.end_y};

    // control points and classification
    always_comb begin
        job.px[0] = sx;
        job.py[0] = sy;
        job.px[1] = sx + {req.start_dir_x[COORD_WIDTH-1], req.start_dir_x};
        job.py[1] = sy + {req.start_dir_y[COORD_WIDTH-1], req.start_dir_y};
        job.px[2] = ex + {req.end_dir_x[COORD_WIDTH-1], req.end_dir_x};
        job.py[2] = ey + {req.end_dir_y[COORD_WIDTH-1], req.end_dir_y};
        job.px[3] = ex;
        job.py[3] = ey;
        job.ctrl  = (req.slice_count == '0);
        if (req.slice_count > SLICE_W'(MAX_SLICES)) begin
            job.n = SLICE_W'(MAX_SLICES);
        end else begin
            job.n = req.slice_count;
        end
    end

endmodule

FILE: hdl/cbf_queue.sv
module cbf_queue #(
    parameter int DEPTH = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  cbf_pkg::job_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output cbf_pkg::job_t pop_data
);
    import cbf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hdl/cbf_back.sv
module cbf_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          job_valid,
    output logic          job_ready,
    input  cbf_pkg::job_t job_in,
    output logic          busy,
    output logic          m_valid,
    input  logic          m_ready,
    output cbf_pkg::out_t m_data
);
    import cbf_pkg::*;

    localparam logic [W_W-1:0] W_ONE = W_W'(1) << 48;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << 47;
    localparam logic signed [RS_W-1:0] SAT_HI = RS_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
    localparam logic signed [RS_W-1:0] SAT_LO = -SAT_HI - RS_W'(1);
    localparam logic [T_W-1:0] T_ONE = T_W'(65536);

    bk_state_t            state_reg, state_next;
    job_t                 job_reg, job_next;
    logic [SLICE_W-1:0]   s_reg, s_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [SLICE_W-1:0]   rem_reg, rem_next;
    logic [T_W-1:0]       q_reg, q_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic [T_W-1:0]       t_reg, t_next, u_reg, u_next;
    logic [SQ_W-1:0]      u2_reg, u2_next, t2_reg, t2_next;
    logic [3:0][W_W-1:0]  w_reg, w_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic                 coord_reg, coord_next;
    logic [1:0]           idx_reg, idx_next;
    logic [1:0]           chunk_reg, chunk_next;
    logic signed [COORD_WIDTH-1:0] rx_reg, rx_next;
    out_t                 out_reg, out_next;
    logic                 m_valid_reg, m_valid_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic [T_W-1:0]            mul_b;
    logic signed [MUL_P_W-1:0] mul_p, mul_p3;
    logic signed [ACC_W-1:0]   prod_ext, prod_sh, rnd;
    logic signed [RS_W-1:0]    rsh;
    logic signed [COORD_WIDTH-1:0] sat_val;
    logic [PT_W-1:0]           pt_sel;
    logic [W_W+1:0]            w_pad;
    logic [SLICE_W:0]          trial;
    logic                      qbit, out_free, last_pt, mac_done;

    assign out_free  = !m_valid_reg || m_ready;
    assign last_pt   = job_reg.ctrl ? (s_reg == SLICE_W'(3)) : (s_reg == job_reg.n);
    assign mac_done  = (idx_reg == 2'd3) && (chunk_reg == 2'(CHUNKS - 1));
    assign job_ready = (state_reg == BK_IDLE);
    assign busy      = (state_reg != BK_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (job_valid) state_next = BK_PREP;
            BK_PREP: state_next = job_reg.ctrl ? BK_MAC : BK_DIV;
            BK_DIV:  if (cnt_reg == 5'(NUM_W - 1)) state_next = BK_WGT;
            BK_WGT:  if (cnt_reg == 5'(WGT_STEPS - 1)) state_next = BK_MAC;
            BK_MAC:  if (mac_done) state_next = BK_RND;
            BK_RND:  state_next = coord_reg ? BK_OUT : BK_MAC;
            BK_OUT: begin
                if (out_free) state_next = last_pt ? BK_IDLE : BK_PREP;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // shared multiplier operands
    always_comb begin
        pt_sel = coord_reg ? job_reg.py[idx_reg] : job_reg.px[idx_reg];
        w_pad  = {2'b00, w_reg[idx_reg]};
        mul_a  = '0;
        mul_b  = '0;
        if (state_reg == BK_MAC) begin
            mul_a = {pt_sel[PT_W-1], pt_sel};
            mul_b = w_pad[chunk_reg * T_W +: T_W];
        end else begin
            case (cnt_reg)
                WS_U2: begin mul_a = MUL_A_W'(u_reg);  mul_b = u_reg; end
                WS_T2: begin mul_a = MUL_A_W'(t_reg);  mul_b = t_reg; end
                WS_W0: begin mul_a = MUL_A_W'(u2_reg); mul_b = u_reg; end
                WS_W3: begin mul_a = MUL_A_W'(t2_reg); mul_b = t_reg; end
                WS_W1: begin mul_a = MUL_A_W'(u2_reg); mul_b = t_reg; end
                WS_W2: begin mul_a = MUL_A_W'(t2_reg); mul_b = u_reg; end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
        mul_p    = mul_a * $signed({1'b0, mul_b});
        mul_p3   = mul_p + (mul_p <<< 1);
        prod_ext = {{(ACC_W - MUL_P_W){mul_p[MUL_P_W-1]}}, mul_p};
        case (chunk_reg)
            2'd1:    prod_sh = prod_ext <<< T_W;
            2'd2:    prod_sh = prod_ext <<< (2 * T_W);
            default: prod_sh = prod_ext;
        endcase
    end

    // divider step, rounding and saturation
    always_comb begin
        trial = {rem_reg, num_reg[NUM_W-1]};
        qbit  = (trial >= {1'b0, job_reg.n});
        rnd   = acc_reg + HALF;
        rsh   = rnd[ACC_W-1:48];
        if (rsh > SAT_HI) begin
            sat_val = COORD_WIDTH'(SAT_HI);
        end else if (rsh < SAT_LO) begin
            sat_val = COORD_WIDTH'(SAT_LO);
        end else begin
            sat_val = rsh[COORD_WIDTH-1:0];
        end
    end

    // datapath updates
    always_comb begin
        job_next   = job_reg;
        s_next     = s_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        t_next     = t_reg;
        u_next     = u_reg;
        u2_next    = u2_reg;
        t2_next    = t2_reg;
        w_next     = w_reg;
        acc_next   = acc_reg;
        coord_next = coord_reg;
        idx_next   = idx_reg;
        chunk_next = chunk_reg;
        rx_next    = rx_reg;
        out_next   = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            BK_IDLE: begin
                job_next = job_in;
                s_next   = '0;
            end
            BK_PREP: begin
                num_next   = {s_reg, 16'b0} + NUM_W'(job_reg.n >> 1);
                rem_next   = '0;
                q_next     = '0;
                cnt_next   = '0;
                acc_next   = '0;
                coord_next = 1'b0;
                idx_next   = '0;
                chunk_next = '0;
                for (int k = 0; k < 4; k++) begin
                    w_next[k] = (s_reg == SLICE_W'(k)) ? W_ONE : '0;
                end
            end
            BK_DIV: begin
                num_next = num_reg << 1;
                q_next   = {q_reg[T_W-2:0], qbit};
                rem_next = qbit ? SLICE_W'(trial - {1'b0, job_reg.n}) : trial[SLICE_W-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'(NUM_W - 1)) begin
                    t_next   = {q_reg[T_W-2:0], qbit};
                    u_next   = T_ONE - {q_reg[T_W-2:0], qbit};
                    cnt_next = '0;
                end
            end
            BK_WGT: begin
                cnt_next = cnt_reg + 1'b1;
                case (cnt_reg)
                    WS_U2:   u2_next   = mul_p[SQ_W-1:0];
                    WS_T2:   t2_next   = mul_p[SQ_W-1:0];
                    WS_W0:   w_next[0] = mul_p[W_W-1:0];
                    WS_W3:   w_next[3] = mul_p[W_W-1:0];
                    WS_W1:   w_next[1] = mul_p3[W_W-1:0];
                    WS_W2:   w_next[2] = mul_p3[W_W-1:0];
                    default: cnt_next  = '0;
                endcase
            end
            BK_MAC: begin
                acc_next = acc_reg + prod_sh;
                if (chunk_reg == 2'(CHUNKS - 1)) begin
                    chunk_next = '0;
                    idx_next   = idx_reg + 1'b1;
                end else begin
                    chunk_next = chunk_reg + 1'b1;
                end
            end
            BK_RND: begin
                coord_next = 1'b1;
                idx_next   = '0;
                chunk_next = '0;
                // x is kept aside; y stays in the accumulator until hand-off
                if (!coord_reg) begin
                    rx_next  = sat_val;
                    acc_next = '0;
                end
            end
            BK_OUT: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    s_next              = s_reg + 1'b1;
                    out_next.point_x    = rx_reg;
                    out_next.point_y    = sat_val;
                    out_next.last_point = last_pt;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        job_reg   <= job_next;
        s_reg     <= s_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        cnt_reg   <= cnt_next;
        t_reg     <= t_next;
        u_reg     <= u_next;
        u2_reg    <= u2_next;
        t2_reg    <= t2_next;
        w_reg     <= w_next;
        acc_reg   <= acc_next;
        coord_reg <= coord_next;
        idx_reg   <= idx_next;
        chunk_reg <= chunk_next;
        rx_reg    <= rx_next;
        if (state_reg != BK_OUT || out_free) begin
            out_reg <= out_next;
        end
    end

endmodule
